[rtl/iol_pkg.sv]
// Package: sizes, operation and status codes, and FSM states of the indexed ordered list.
`default_nettype none
package iol_pkg;
	localparam int CAPACITY = 64;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
	localparam int VAL_W = 32;
	localparam int POS_W = 8;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;
	localparam int LEN_W = 7;

	localparam logic [KIND_W-1:0] KIND_GET = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT_AT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INSERT_HEAD = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INSERT_TAIL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

	localparam logic [STAT_W-1:0] STATUS_DONE = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_BAD_POSITION = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GET,
		ST_SHIFT,
		ST_DRAIN,
		ST_PUT,
		ST_RESULT
	} state_t;
endpackage
`default_nettype wire

[rtl/iol_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module iol_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/indexed_ordered_list.sv]
// Get reads one entry; insert at p below the length shifts the entries from p up before writing the
// value, insert at the tail writes it without a shift, and delete at p below length - 1 shifts the entries
// above p down; delete of the last entry and every invalid or refused beat go straight to the result.
// One item is worked on at a time: s_tready returns the cycle after the result beat is
// registered, and a shift moves one entry per cycle through the RAM, reading one entry while
// writing the one read in the cycle before. Reset clears the length, the FSM and the output
// valid; the entry RAM is not cleared, since only positions below the length are ever read.
`default_nettype none
module indexed_ordered_list
	import iol_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // position[7:0], value[39:8]
	input  wire logic [2:0]  s_tuser,  // kind[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,  // read_value[31:0], length[38:32], zero[39]
	output logic      [1:0]  m_tuser   // status[1:0]
);
	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  at_q, rp_q, stop_q, wa_s1;
	logic              up_q, pend_s1;
	logic [VAL_W-1:0]  value_q, res_value_q;
	logic [STAT_W-1:0] res_status_q;
	logic [CNT_W-1:0]  res_count_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [VAL_W-1:0]  ram_wdata, ram_rdata;

	logic [KIND_W-1:0] kind;
	logic [POS_W-1:0]  position;
	logic [VAL_W-1:0]  value;
	logic              neg;
	logic [CMP_W-1:0]  posw, cntw, ins_at;
	logic              ins_ok, full, accept, out_free;

	logic [STAT_W-1:0] dec_status;
	logic [VAL_W-1:0]  dec_value;
	logic [CNT_W-1:0]  dec_count;
	state_t            dec_next;
	logic [IDX_W-1:0]  dec_at, dec_rp, dec_stop;
	logic              dec_up;

	assign kind = s_tuser;
	assign position = s_tdata[POS_W-1:0];
	assign value = s_tdata[POS_W+VAL_W-1:POS_W];
	assign neg = position[POS_W-1];
	assign posw = CMP_W'(position[POS_W-2:0]);
	assign cntw = CMP_W'(count_q);
	assign full = (cntw == CMP_W'(CAPACITY));
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	// Decode of the incoming beat against the current length.
	always_comb begin
		dec_status = STATUS_BAD_POSITION;
		dec_value = '0;
		dec_count = count_q;
		dec_next = ST_RESULT;
		dec_at = '0;
		dec_rp = '0;
		dec_stop = '0;
		dec_up = 1'b1;
		ins_at = '0;
		ins_ok = 1'b0;
		case (kind)
			KIND_GET: begin
				if (!neg && posw < cntw) begin
					dec_status = STATUS_DONE;
					dec_next = ST_GET;
				end else begin
					dec_value = '1;
				end
			end
			KIND_INSERT_AT, KIND_INSERT_HEAD, KIND_INSERT_TAIL: begin
				if (kind == KIND_INSERT_AT) begin
					ins_at = neg ? '0 : posw;
				end else if (kind == KIND_INSERT_TAIL) begin
					ins_at = cntw;
				end
				ins_ok = (ins_at <= cntw);
				if (ins_ok) begin
					if (full) begin
						dec_status = STATUS_FULL;
					end else begin
						dec_status = STATUS_DONE;
						dec_count = count_q + CNT_W'(1);
						dec_at = ins_at[IDX_W-1:0];
						dec_rp = IDX_W'(cntw - CMP_W'(1));
						dec_stop = ins_at[IDX_W-1:0];
						dec_up = 1'b1;
						dec_next = (ins_at == cntw) ? ST_PUT : ST_SHIFT;
					end
				end
			end
			KIND_DELETE: begin
				if (!neg && posw < cntw) begin
					dec_status = STATUS_DONE;
					dec_count = count_q - CNT_W'(1);
					dec_rp = IDX_W'(posw + CMP_W'(1));
					dec_stop = IDX_W'(cntw - CMP_W'(1));
					dec_up = 1'b0;
					dec_next = (posw == cntw - CMP_W'(1)) ? ST_RESULT : ST_SHIFT;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = dec_next;
				end
			end
			ST_GET: state_d = ST_RESULT;
			ST_SHIFT: begin
				if (rp_q == stop_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = up_q ? ST_PUT : ST_RESULT;
			ST_PUT: state_d = ST_RESULT;
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// The entry read in one shift cycle is written one place up or down in the next.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		ram_raddr = posw[IDX_W-1:0];
		ram_we = pend_s1;
		ram_waddr = wa_s1;
		ram_wdata = ram_rdata;
		case (state_q)
			ST_SHIFT: ram_raddr = rp_q;
			ST_PUT: begin
				ram_we = 1'b1;
				ram_waddr = at_q;
				ram_wdata = value_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == ST_SHIFT);
			if (accept) begin
				count_q <= dec_count;
			end
			if (state_q == ST_RESULT && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= dec_status;
			res_value_q <= dec_value;
			res_count_q <= dec_count;
			at_q <= dec_at;
			rp_q <= dec_rp;
			stop_q <= dec_stop;
			up_q <= dec_up;
			value_q <= value;
		end
		if (state_q == ST_GET) begin
			res_value_q <= ram_rdata;
		end
		if (state_q == ST_SHIFT) begin
			rp_q <= up_q ? rp_q - IDX_W'(1) : rp_q + IDX_W'(1);
			wa_s1 <= up_q ? rp_q + IDX_W'(1) : rp_q - IDX_W'(1);
		end
		if (state_q == ST_RESULT && out_free) begin
			m_tdata <= {1'b0, LEN_W'(res_count_q), res_value_q};
			m_tuser <= res_status_q;
		end
	end

	iol_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cntw <= CMP_W'(CAPACITY))
		else $error("list length exceeds capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !ram_we)
		else $error("entry RAM written while idle");

	a_shift_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && state_q == ST_SHIFT) |-> wa_s1 != ram_raddr)
		else $error("shift writes the entry being read");

	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == STATUS_FULL) |-> m_tdata[38:32] == LEN_W'(CAPACITY))
		else $error("refused insert reported with a list that is not full");

	a_drain_follows_shift: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> pend_s1)
		else $error("drain cycle without a pending shift write");
endmodule
`default_nettype wire

[dv/indexed_ordered_list_test.sv]
// Self-checking testbench for the indexed ordered list: directed and random list operations.
module indexed_ordered_list_test;
	import iol_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = CAPACITY + 8;
	localparam int MAX_GAP = 16;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [VAL_W-1:0]  read_value;
		logic [STAT_W-1:0] status;
		logic [LEN_W-1:0]  length;
	} list_reply_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [39:0]       s_tdata;
	logic [2:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [39:0]       m_tdata;
	logic [1:0]        m_tuser;

	logic [VAL_W-1:0]  shadow_vals [CAPACITY];
	int                shadow_len = 0;
	list_reply_t       pending_replies [$];
	int                err_count = 0;
	int                cycle_count = 0;
	int                idle_pct = 0;
	int                stall_pct = 0;

	indexed_ordered_list i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [STAT_W-1:0] shadow_put(input int at, input logic [VAL_W-1:0] val);
		if (shadow_len >= CAPACITY) begin
			return STATUS_FULL;
		end
		for (int k = shadow_len; k > at; k--) begin
			shadow_vals[k] = shadow_vals[k-1];
		end
		shadow_vals[at] = val;
		shadow_len++;
		return STATUS_DONE;
	endfunction

	// Updates the shadow list and returns the reply the block must give for this beat.
	function automatic list_reply_t apply_list_op(input logic [KIND_W-1:0] kind,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val);
		list_reply_t r;
		int idx;
		bit negative;
		negative = pos[POS_W-1];
		idx = int'(pos[POS_W-2:0]);
		r.kind = kind;
		r.read_value = '0;
		r.status = STATUS_BAD_POSITION;
		case (kind)
			KIND_GET: begin
				if (!negative && idx < shadow_len) begin
					r.read_value = shadow_vals[idx];
					r.status = STATUS_DONE;
				end else begin
					r.read_value = '1;
				end
			end
			KIND_INSERT_AT: begin
				if (negative) begin
					idx = 0;
				end
				// The range check comes before the full check.
				if (idx <= shadow_len) begin
					r.status = shadow_put(idx, val);
				end
			end
			KIND_INSERT_HEAD: r.status = shadow_put(0, val);
			KIND_INSERT_TAIL: r.status = shadow_put(shadow_len, val);
			KIND_DELETE: begin
				if (!negative && idx < shadow_len) begin
					for (int k = idx; k + 1 < shadow_len; k++) begin
						shadow_vals[k] = shadow_vals[k+1];
					end
					shadow_len--;
					r.status = STATUS_DONE;
				end
			end
			default: ;
		endcase
		r.length = LEN_W'(shadow_len);
		return r;
	endfunction

	function automatic void note_error(input string msg);
		err_count++;
		if (err_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// Mostly a position inside the given span, otherwise any 8-bit pattern.
	function automatic logic [POS_W-1:0] pick_position(input int span);
		if (span > 0 && $urandom_range(9) < 8) begin
			return POS_W'($urandom_range(span - 1));
		end
		return POS_W'($urandom_range(255));
	endfunction

	task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {val, pos};
		s_tuser = kind;
		do @(posedge clk); while (!s_tready);
		pending_replies.push_back(apply_list_op(kind, pos, val));
	endtask

	task automatic wait_for_replies();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_list();
		send_op(KIND_GET, 8'd0, 32'd0);
		send_op(KIND_GET, 8'h80, 32'd0);
		send_op(KIND_DELETE, 8'd0, 32'd0);
		send_op(KIND_DELETE, 8'hFF, 32'd0);
		send_op(KIND_INSERT_AT, 8'd1, 32'h1234_5678);
		for (int k = int'(KIND_DELETE) + 1; k < (1 << KIND_W); k++) begin
			send_op(KIND_W'(k), 8'd0, 32'hDEAD_BEEF);
		end
	endtask

	task automatic test_insert_kinds();
		send_op(KIND_INSERT_HEAD, 8'd0, 32'h7FFF_FFFF);
		send_op(KIND_INSERT_TAIL, 8'd0, 32'h8000_0000);
		send_op(KIND_INSERT_AT, 8'd1, 32'h0000_0000);
		// A negative position lands at the head.
		send_op(KIND_INSERT_AT, 8'h80, 32'hFFFF_FFFF);
		send_op(KIND_INSERT_AT, 8'd4, 32'h5A5A_5A5A);
		send_op(KIND_INSERT_AT, 8'h7F, 32'hA5A5_A5A5);
		for (int k = 0; k <= 5; k++) begin
			send_op(KIND_GET, POS_W'(k), 32'd0);
		end
		send_op(KIND_GET, 8'h7F, 32'd0);
	endtask

	task automatic test_delete_positions();
		send_op(KIND_DELETE, 8'd4, 32'd0);
		send_op(KIND_DELETE, 8'd0, 32'd0);
		send_op(KIND_DELETE, 8'd1, 32'd0);
		send_op(KIND_DELETE, 8'd2, 32'd0);
		send_op(KIND_GET, 8'd0, 32'd0);
		send_op(KIND_GET, 8'd1, 32'd0);
	endtask

	task automatic test_random_mix(input int count);
		int r;
		bit grow;
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0] pos;
		grow = 1'b1;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				grow = $urandom_range(1);
			end
			r = $urandom_range(99);
			if (r < 20) begin
				kind = KIND_GET;
			end else if (r < (grow ? 65 : 40)) begin
				kind = KIND_W'(int'(KIND_INSERT_AT) + $urandom_range(2));
			end else if (r < 96) begin
				kind = KIND_DELETE;
			end else begin
				kind = KIND_W'(int'(KIND_DELETE) + 1 + $urandom_range(2));
			end
			if (kind == KIND_INSERT_AT) begin
				pos = pick_position(shadow_len + 1);
			end else begin
				pos = pick_position(shadow_len);
			end
			send_op(kind, pos, $urandom());
		end
	endtask

	task automatic test_fill_and_drain();
		logic [KIND_W-1:0] kind;
		while (shadow_len < CAPACITY) begin
			kind = KIND_W'(int'(KIND_INSERT_AT) + $urandom_range(2));
			send_op(kind, pick_position(shadow_len + 1), $urandom());
		end
		// Full list: every insert kind is refused, an out-of-range one is flagged as such.
		send_op(KIND_INSERT_HEAD, pick_position(CAPACITY), $urandom());
		send_op(KIND_INSERT_TAIL, pick_position(CAPACITY), $urandom());
		send_op(KIND_INSERT_AT, POS_W'($urandom_range(CAPACITY)), $urandom());
		send_op(KIND_INSERT_AT, POS_W'(CAPACITY + 1 + $urandom_range(126 - CAPACITY)),
			$urandom());
		send_op(KIND_GET, POS_W'(CAPACITY - 1), 32'd0);
		send_op(KIND_GET, POS_W'(CAPACITY), 32'd0);
		while (shadow_len > 0) begin
			if ($urandom_range(4) == 0) begin
				send_op(KIND_GET, pick_position(shadow_len), $urandom());
			end
			send_op(KIND_DELETE, pick_position(shadow_len), $urandom());
		end
	endtask

	task automatic run_phase(input int sender_idle, input int receiver_stall);
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		test_random_mix(150);
		test_fill_and_drain();
		wait_for_replies();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_insert_kinds();
		test_delete_positions();
		wait_for_replies();

		run_phase(0, 0);
		run_phase(50, 0);
		run_phase(0, 50);
		run_phase(32, 32);

		wait_for_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_replies.size() == 0) begin
			$display("indexed_ordered_list_test: clean");
		end else begin
			$display("indexed_ordered_list_test: errors");
		end
		$finish;
	end

	// Receiver back-pressure, redrawn every cycle.
	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		list_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				note_error($sformatf("unexpected reply: read_value=%0d status=%0d length=%0d",
					$signed(m_tdata[31:0]), m_tuser, m_tdata[38:32]));
			end else begin
				want = pending_replies.pop_front();
				if (m_tdata[31:0] !== want.read_value || m_tuser !== want.status ||
						m_tdata[38:32] !== want.length) begin
					note_error($sformatf(
						"kind %0d: expected rd=%0d st=%0d len=%0d, got rd=%0d st=%0d len=%0d",
						want.kind, $signed(want.read_value), want.status, want.length,
						$signed(m_tdata[31:0]), m_tuser, m_tdata[38:32]));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("indexed_ordered_list_test: errors");
			$finish;
		end
	end
endmodule
